>>> rtl/scps_pkg.sv
// ----------------------------------------------------------------------------
// scps_pkg: shared types and constants for the sprite clip and page split unit
// Payload structs, the queued job record, state encodings, the saturating
// working-range helpers and the configuration register indexes.
// ----------------------------------------------------------------------------
package scps_pkg;

	localparam int WORK_W = 32;
	localparam int WIDE_W = 34;
	localparam int PROD_W = 2 * WORK_W;
	localparam int FIFO_DEPTH = 2;

	typedef logic signed [WORK_W-1:0] word_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam word_t WORK_MAX = 32'sh3FFF_FFFF;
	localparam word_t WORK_MIN = 32'shC000_0000;

	localparam logic [1:0] CFG_VIEW_W = 2'd0;
	localparam logic [1:0] CFG_VIEW_H = 2'd1;
	localparam logic [1:0] CFG_ORIGIN_X = 2'd2;
	localparam logic [1:0] CFG_ORIGIN_Y = 2'd3;

	typedef struct packed {
		logic signed [23:0] dest_x;
		logic signed [23:0] dest_y;
		logic [22:0] dest_w;
		logic [22:0] dest_h;
		logic signed [23:0] source_x;
		logic signed [23:0] source_y;
		logic [22:0] source_w;
		logic [22:0] source_h;
		logic [1:0] flip_code;
		logic [12:0] texture_w;
		logic [12:0] texture_h;
		logic [1:0] pages_present;
	} sprite_t;

	typedef struct packed {
		logic [1:0] page_index;
		logic signed [23:0] out_dest_x;
		logic signed [23:0] out_dest_y;
		logic signed [23:0] out_dest_w;
		logic signed [23:0] out_dest_h;
		logic signed [23:0] out_source_x;
		logic signed [23:0] out_source_y;
		logic signed [23:0] out_source_w;
		logic signed [23:0] out_source_h;
		logic [1:0] out_flip;
		logic last_piece;
	} draw_t;

	typedef enum logic [1:0] {
		CLIP_NONE,
		CLIP_NEG,
		CLIP_OVER
	} clip_e;

	typedef struct packed {
		logic signed [23:0] dx;
		logic signed [23:0] dy;
		logic [22:0] dw;
		logic [22:0] dh;
		logic signed [23:0] sx;
		logic signed [23:0] sy;
		logic [22:0] sw;
		logic [22:0] sh;
		logic [1:0] flip;
		logic [11:0] tw_half;
		logic [11:0] th_half;
		logic [1:0] pages;
		clip_e xcase;
		logic xwide;
		clip_e ycase;
		logic ywide;
	} job_t;

	typedef struct packed {
		logic start;
		word_t a;
		word_t b;
		word_t c;
	} md_req_t;

	typedef struct packed {
		logic done;
		word_t q;
	} md_rsp_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV,
		MD_DONE
	} md_state_e;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_X0,
		ST_X1,
		ST_X2,
		ST_Y0,
		ST_Y1,
		ST_Y2,
		ST_TX,
		ST_TY,
		ST_PG,
		ST_PT,
		ST_ET,
		ST_EM
	} back_state_e;

	function automatic wide_t wext(input word_t v);
		return wide_t'(v);
	endfunction

	function automatic word_t sat_w(input wide_t v);
		if (v > wide_t'(WORK_MAX)) begin
			return WORK_MAX;
		end
		if (v < wide_t'(WORK_MIN)) begin
			return WORK_MIN;
		end
		return word_t'(v);
	endfunction

	function automatic logic [WORK_W-1:0] mag(input word_t v);
		logic [WORK_W-1:0] u;
		u = v;
		return v[WORK_W-1] ? (~u + 1'b1) : u;
	endfunction

endpackage

>>> rtl/sprite_clip_and_page_split_unit.sv
// ----------------------------------------------------------------------------
// sprite_clip_and_page_split_unit: sprite blitter clip and page split
// Culls, auto-flips and clips sprite draws to the viewport and texture, then
// splits them across texture pages into zero, one or two draw commands.
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  sprite    sprite_valid / sprite_stall   sprite_t, one draw request
//  draw      draw_valid / draw_stall       draw_t, one draw command
//  cfg       cfg_valid / cfg_ready         cfg_index, cfg_data
//
// The front takes a sprite every cycle until its two-entry job queue is full.
// The back handles one job at a time: each scaled edge goes through the shared
// multiply-divide unit (a multiply step, then one quotient bit per cycle), and
// a job needs zero to nine of them. Reset loads the viewport registers with
// 400, 300, 0 and 0; nothing is cleared after reset. A stalled draw command
// holds in the output register, and the back waits only when it has the next
// command ready.
module sprite_clip_and_page_split_unit #(
	parameter int PAGE_ROWS = 1024,
	parameter int FRAC_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic sprite_valid,
	output logic sprite_stall,
	input scps_pkg::sprite_t sprite,
	output logic draw_valid,
	input logic draw_stall,
	output scps_pkg::draw_t draw,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [10:0] cfg_data
);

	logic [9:0] view_w_q;
	logic [9:0] view_h_q;
	logic signed [10:0] origin_x_q;
	logic signed [10:0] origin_y_q;
	scps_pkg::job_t front_job;
	scps_pkg::job_t back_job;
	logic keep;
	logic fifo_full;
	logic fifo_not_empty;
	logic job_pop;
	scps_pkg::md_req_t md_req;
	scps_pkg::md_rsp_t md_rsp;

	assign cfg_ready = 1'b1;
	assign sprite_stall = fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_w_q <= 10'd400;
			view_h_q <= 10'd300;
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				scps_pkg::CFG_VIEW_W: view_w_q <= cfg_data[9:0];
				scps_pkg::CFG_VIEW_H: view_h_q <= cfg_data[9:0];
				scps_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data;
				scps_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data;
			endcase
		end
	end

	scps_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.sprite(sprite),
		.view_w(view_w_q),
		.view_h(view_h_q),
		.job(front_job),
		.keep(keep)
	);

	scps_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(sprite_valid && keep),
		.wr_data(front_job),
		.full(fifo_full),
		.pop(job_pop),
		.not_empty(fifo_not_empty),
		.rd_data(back_job)
	);

	scps_muldiv u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.req(md_req),
		.rsp(md_rsp)
	);

	scps_back #(
		.PAGE_ROWS(PAGE_ROWS),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job(back_job),
		.job_valid(fifo_not_empty),
		.job_pop(job_pop),
		.view_w(view_w_q),
		.view_h(view_h_q),
		.origin_x(origin_x_q),
		.origin_y(origin_y_q),
		.md_req(md_req),
		.md_rsp(md_rsp),
		.draw_valid(draw_valid),
		.draw_stall(draw_stall),
		.draw(draw)
	);

endmodule

>>> rtl/scps_front.sv
// ----------------------------------------------------------------------------
// scps_front: sprite intake and classification
// Culls draws that start past the viewport, applies the automatic flip from
// the source row and classifies the horizontal and vertical clip cases.
// ----------------------------------------------------------------------------
module scps_front #(
	parameter int FRAC_BITS = 8
) (
	input scps_pkg::sprite_t sprite,
	input logic [9:0] view_w,
	input logic [9:0] view_h,
	output scps_pkg::job_t job,
	output logic keep
);

	scps_pkg::word_t vw;
	scps_pkg::word_t vh;
	scps_pkg::word_t th;
	scps_pkg::word_t dx;
	scps_pkg::word_t dy;
	scps_pkg::word_t dw;
	scps_pkg::word_t dh;
	scps_pkg::word_t sy;
	logic [1:0] mode;

	always_comb begin
		vw = scps_pkg::word_t'(view_w) << FRAC_BITS;
		vh = scps_pkg::word_t'(view_h) << FRAC_BITS;
		th = scps_pkg::word_t'(sprite.texture_h[12:1]) << FRAC_BITS;
		dx = scps_pkg::word_t'(sprite.dest_x);
		dy = scps_pkg::word_t'(sprite.dest_y);
		dw = scps_pkg::word_t'(sprite.dest_w);
		dh = scps_pkg::word_t'(sprite.dest_h);
		sy = scps_pkg::word_t'(sprite.source_y);
		mode = 2'd0;
		for (int i = 0; i < 3; i++) begin
			if (sy >= th) begin
				sy = sy - th;
				mode = mode + 2'd1;
			end
		end

		keep = !(dx > vw || dy > vh);

		job.dx = sprite.dest_x;
		job.dy = sprite.dest_y;
		job.dw = sprite.dest_w;
		job.dh = sprite.dest_h;
		job.sx = sprite.source_x;
		job.sy = sy[23:0];
		job.sw = sprite.source_w;
		job.sh = sprite.source_h;
		job.flip = sprite.flip_code ^ mode;
		job.tw_half = sprite.texture_w[12:1];
		job.th_half = sprite.texture_h[12:1];
		job.pages = sprite.pages_present;

		job.xwide = (scps_pkg::wext(dw) + scps_pkg::wext(dx)) > scps_pkg::wext(vw);
		job.ywide = (scps_pkg::wext(dh) + scps_pkg::wext(dy)) > scps_pkg::wext(vh);
		if (dx < 0) begin
			job.xcase = scps_pkg::CLIP_NEG;
		end else if (job.xwide) begin
			job.xcase = scps_pkg::CLIP_OVER;
		end else begin
			job.xcase = scps_pkg::CLIP_NONE;
		end
		if (dy < 0) begin
			job.ycase = scps_pkg::CLIP_NEG;
		end else if (job.ywide) begin
			job.ycase = scps_pkg::CLIP_OVER;
		end else begin
			job.ycase = scps_pkg::CLIP_NONE;
		end
	end

endmodule

>>> rtl/scps_fifo.sv
// ----------------------------------------------------------------------------
// scps_fifo: job queue between the front and the back
// A short first-in first-out buffer of classified jobs.
// ----------------------------------------------------------------------------
module scps_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input scps_pkg::job_t wr_data,
	output logic full,
	input logic pop,
	output logic not_empty,
	output scps_pkg::job_t rd_data
);

	localparam int DEPTH = scps_pkg::FIFO_DEPTH;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	scps_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/scps_muldiv.sv
// ----------------------------------------------------------------------------
// scps_muldiv: scaled edge unit
// Computes (a*b)/c truncated toward zero, zero for a zero divisor, saturated
// to the working range. A multiply step, then one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scps_muldiv (
	input logic clk,
	input logic arst_n,
	input scps_pkg::md_req_t req,
	output scps_pkg::md_rsp_t rsp
);

	localparam int PW = scps_pkg::PROD_W;
	localparam int WW = scps_pkg::WORK_W;
	localparam int CNT_W = $clog2(PW);
	localparam logic [PW-1:0] POS_LIM = PW'(scps_pkg::WORK_MAX);
	localparam logic [PW-1:0] NEG_LIM = POS_LIM + 1'b1;

	scps_pkg::md_state_e state_q;
	scps_pkg::md_state_e state_d;
	logic [WW-1:0] a_mag_q;
	logic [WW-1:0] b_mag_q;
	logic [WW-1:0] c_mag_q;
	logic neg_q;
	logic zero_q;
	logic [WW-1:0] rem_q;
	logic [PW-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WW:0] rem_sh;
	logic ge;

	assign rem_sh = {rem_q, quo_q[PW-1]};
	assign ge = rem_sh >= {1'b0, c_mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scps_pkg::MD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rsp.done = 1'b0;
		rsp.q = '0;
		unique case (state_q)
			scps_pkg::MD_IDLE: begin
				if (req.start) begin
					state_d = scps_pkg::MD_MUL;
				end
			end
			scps_pkg::MD_MUL: begin
				state_d = scps_pkg::MD_DIV;
			end
			scps_pkg::MD_DIV: begin
				if (cnt_q == CNT_W'(PW - 1)) begin
					state_d = scps_pkg::MD_DONE;
				end
			end
			scps_pkg::MD_DONE: begin
				rsp.done = 1'b1;
				if (zero_q) begin
					rsp.q = '0;
				end else if (neg_q) begin
					rsp.q = (quo_q > NEG_LIM) ? scps_pkg::WORK_MIN
						: -scps_pkg::word_t'(quo_q[WW-1:0]);
				end else begin
					rsp.q = (quo_q > POS_LIM) ? scps_pkg::WORK_MAX
						: scps_pkg::word_t'(quo_q[WW-1:0]);
				end
				state_d = scps_pkg::MD_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			scps_pkg::MD_IDLE: begin
				if (req.start) begin
					a_mag_q <= scps_pkg::mag(req.a);
					b_mag_q <= scps_pkg::mag(req.b);
					c_mag_q <= scps_pkg::mag(req.c);
					neg_q <= req.a[WW-1] ^ req.b[WW-1] ^ req.c[WW-1];
					zero_q <= req.c == '0;
				end
			end
			scps_pkg::MD_MUL: begin
				quo_q <= a_mag_q * b_mag_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			scps_pkg::MD_DIV: begin
				rem_q <= ge ? WW'(rem_sh - {1'b0, c_mag_q}) : rem_sh[WW-1:0];
				quo_q <= {quo_q[PW-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			scps_pkg::MD_DONE: begin
			end
		endcase
	end

endmodule

>>> rtl/scps_back.sv
// ----------------------------------------------------------------------------
// scps_back: clip, texture clamp and page split sequencer
// Takes one queued job at a time, runs its scaled edges through the shared
// multiply-divide unit and emits up to two draw commands through an output
// register.
// ----------------------------------------------------------------------------
module scps_back #(
	parameter int PAGE_ROWS = 1024,
	parameter int FRAC_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input scps_pkg::job_t job,
	input logic job_valid,
	output logic job_pop,
	input logic [9:0] view_w,
	input logic [9:0] view_h,
	input logic signed [10:0] origin_x,
	input logic signed [10:0] origin_y,
	output scps_pkg::md_req_t md_req,
	input scps_pkg::md_rsp_t md_rsp,
	output logic draw_valid,
	input logic draw_stall,
	output scps_pkg::draw_t draw
);

	localparam scps_pkg::word_t PG = scps_pkg::word_t'(PAGE_ROWS << FRAC_BITS);
	localparam scps_pkg::word_t PG2 = scps_pkg::word_t'((2 * PAGE_ROWS) << FRAC_BITS);

	scps_pkg::back_state_e state_q;
	scps_pkg::back_state_e state_d;
	logic issued_q;
	scps_pkg::word_t dx_q, dy_q, dw_q, dh_q, sx_q, sy_q, sw_q, sh_q;
	logic [1:0] flip_q;
	logic [1:0] pages_q;
	logic [11:0] tw_half_q;
	logic [11:0] th_half_q;
	scps_pkg::clip_e xcase_q;
	scps_pkg::clip_e ycase_q;
	logic xwide_q;
	logic ywide_q;
	logic [1:0] main_q;
	logic main_v_q;
	logic [1:0] top_q;
	scps_pkg::word_t part_q;
	logic draw_valid_q;
	scps_pkg::draw_t draw_q;

	scps_pkg::word_t vw, vh, tw, th, ox, oy, m;
	logic md_done;
	logic slot_free;
	logic tx_need;
	logic ty_need;
	logic emit_top;
	logic emit_main;
	scps_pkg::back_state_e y_entry;
	scps_pkg::back_state_e x_entry;
	scps_pkg::wide_t pg_sum;
	scps_pkg::word_t pg_sy1;
	scps_pkg::word_t pg_sy;
	logic [1:0] pg_main;
	logic pg_main_v;
	logic [1:0] pg_top;
	logic pg_top_v;
	scps_pkg::draw_t draw_d;

	function automatic scps_pkg::back_state_e first_y(input scps_pkg::clip_e c,
			input logic fv);
		scps_pkg::back_state_e s;
		unique case (c)
			scps_pkg::CLIP_NEG: s = scps_pkg::ST_Y0;
			scps_pkg::CLIP_OVER: s = fv ? scps_pkg::ST_Y1 : scps_pkg::ST_Y2;
			default: s = scps_pkg::ST_TX;
		endcase
		return s;
	endfunction

	always_comb begin
		vw = scps_pkg::word_t'(view_w) << FRAC_BITS;
		vh = scps_pkg::word_t'(view_h) << FRAC_BITS;
		tw = scps_pkg::word_t'(tw_half_q) << FRAC_BITS;
		th = scps_pkg::word_t'(th_half_q) << FRAC_BITS;
		ox = scps_pkg::word_t'(origin_x) <<< FRAC_BITS;
		oy = scps_pkg::word_t'(origin_y) <<< FRAC_BITS;
		m = md_rsp.q;
		md_done = md_rsp.done && issued_q;
		slot_free = !draw_valid_q || !draw_stall;
		tx_need = (scps_pkg::wext(sx_q) + scps_pkg::wext(sw_q)) > scps_pkg::wext(tw);
		ty_need = (scps_pkg::wext(sy_q) + scps_pkg::wext(sh_q)) > scps_pkg::wext(th);
		y_entry = first_y(ycase_q, flip_q[1]);
		unique case (job.xcase)
			scps_pkg::CLIP_NEG: x_entry = scps_pkg::ST_X0;
			scps_pkg::CLIP_OVER: x_entry = job.flip[0] ? scps_pkg::ST_X1 : scps_pkg::ST_X2;
			default: x_entry = first_y(job.ycase, job.flip[1]);
		endcase
	end

	always_comb begin
		pg_sum = scps_pkg::wext(sy_q) + scps_pkg::wext(sh_q);
		pg_sy1 = sy_q;
		pg_main = 2'd0;
		pg_main_v = 1'b1;
		pg_top = 2'd0;
		pg_top_v = 1'b0;
		pg_sy = sy_q;
		if (pg_sum > scps_pkg::wext(PG)) begin
			if (pg_sum > scps_pkg::wext(PG2)) begin
				pg_main = 2'd2;
				pg_main_v = pages_q[1];
				pg_top = 2'd1;
				pg_top_v = (sy_q < PG2) && pages_q[0];
				pg_sy1 = scps_pkg::sat_w(scps_pkg::wext(sy_q) - scps_pkg::wext(PG));
			end else begin
				pg_main = 2'd1;
				pg_main_v = pages_q[0];
				pg_top = 2'd0;
				pg_top_v = sy_q < PG;
			end
			pg_sy = pg_top_v ? pg_sy1
				: scps_pkg::sat_w(scps_pkg::wext(pg_sy1) - scps_pkg::wext(PG));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scps_pkg::ST_IDLE;
			issued_q <= 1'b0;
			draw_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (md_req.start) begin
				issued_q <= 1'b1;
			end else if (md_rsp.done) begin
				issued_q <= 1'b0;
			end
			if (emit_top || emit_main) begin
				draw_valid_q <= 1'b1;
			end else if (!draw_stall) begin
				draw_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		emit_top = 1'b0;
		emit_main = 1'b0;
		md_req.start = 1'b0;
		md_req.a = '0;
		md_req.b = '0;
		md_req.c = '0;
		unique case (state_q)
			scps_pkg::ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = x_entry;
				end
			end
			scps_pkg::ST_X0: begin
				md_req = '{!issued_q, dx_q, sw_q, dw_q};
				if (md_done) begin
					state_d = xwide_q ? (flip_q[0] ? scps_pkg::ST_X1 : scps_pkg::ST_X2)
						: y_entry;
				end
			end
			scps_pkg::ST_X1: begin
				md_req = '{!issued_q,
					scps_pkg::word_t'(scps_pkg::wext(dw_q) + scps_pkg::wext(dx_q)
						- scps_pkg::wext(vw)), sw_q, dw_q};
				if (md_done) begin
					state_d = scps_pkg::ST_X2;
				end
			end
			scps_pkg::ST_X2: begin
				md_req = '{!issued_q, (xcase_q == scps_pkg::CLIP_NEG) ? vw : vw - dx_q,
					sw_q, dw_q};
				if (md_done) begin
					state_d = y_entry;
				end
			end
			scps_pkg::ST_Y0: begin
				md_req = '{!issued_q, dy_q, sh_q, dh_q};
				if (md_done) begin
					state_d = ywide_q ? (flip_q[1] ? scps_pkg::ST_Y1 : scps_pkg::ST_Y2)
						: scps_pkg::ST_TX;
				end
			end
			scps_pkg::ST_Y1: begin
				md_req = '{!issued_q,
					scps_pkg::word_t'(scps_pkg::wext(dh_q) + scps_pkg::wext(dy_q)
						- scps_pkg::wext(vh)), sh_q, dh_q};
				if (md_done) begin
					state_d = scps_pkg::ST_Y2;
				end
			end
			scps_pkg::ST_Y2: begin
				md_req = '{!issued_q, (ycase_q == scps_pkg::CLIP_NEG) ? vh : vh - dy_q,
					sh_q, dh_q};
				if (md_done) begin
					state_d = scps_pkg::ST_TX;
				end
			end
			scps_pkg::ST_TX: begin
				if (!tx_need) begin
					state_d = scps_pkg::ST_TY;
				end else begin
					md_req = '{!issued_q, tw - sx_q, dw_q, sw_q};
					if (md_done) begin
						state_d = (m < 0) ? scps_pkg::ST_IDLE : scps_pkg::ST_TY;
					end
				end
			end
			scps_pkg::ST_TY: begin
				if (!ty_need) begin
					state_d = scps_pkg::ST_PG;
				end else begin
					md_req = '{!issued_q, th - sy_q, dh_q, sh_q};
					if (md_done) begin
						state_d = (m < 0) ? scps_pkg::ST_IDLE : scps_pkg::ST_PG;
					end
				end
			end
			scps_pkg::ST_PG: begin
				if (pg_top_v) begin
					state_d = scps_pkg::ST_PT;
				end else if (pg_main_v) begin
					state_d = scps_pkg::ST_EM;
				end else begin
					state_d = scps_pkg::ST_IDLE;
				end
			end
			scps_pkg::ST_PT: begin
				md_req = '{!issued_q, PG - sy_q, dh_q, sh_q};
				if (md_done) begin
					state_d = scps_pkg::ST_ET;
				end
			end
			scps_pkg::ST_ET: begin
				if (slot_free) begin
					emit_top = 1'b1;
					state_d = main_v_q ? scps_pkg::ST_EM : scps_pkg::ST_IDLE;
				end
			end
			scps_pkg::ST_EM: begin
				if (slot_free) begin
					emit_main = 1'b1;
					state_d = scps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = scps_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		draw_d.page_index = emit_top ? top_q : main_q;
		draw_d.out_dest_x = 24'(scps_pkg::sat_w(scps_pkg::wext(dx_q) + scps_pkg::wext(ox)));
		draw_d.out_dest_y = 24'(scps_pkg::sat_w(scps_pkg::wext(dy_q) + scps_pkg::wext(oy)));
		draw_d.out_dest_w = dw_q[23:0];
		draw_d.out_dest_h = emit_top ? part_q[23:0] : dh_q[23:0];
		draw_d.out_source_x = sx_q[23:0];
		draw_d.out_source_y = sy_q[23:0];
		draw_d.out_source_w = sw_q[23:0];
		draw_d.out_source_h = emit_top
			? 24'(scps_pkg::sat_w(scps_pkg::wext(PG) - scps_pkg::wext(sy_q)))
			: sh_q[23:0];
		draw_d.out_flip = flip_q;
		draw_d.last_piece = emit_top ? !main_v_q : 1'b1;
	end

	always_ff @(posedge clk) begin
		if (emit_top || emit_main) begin
			draw_q <= draw_d;
		end
		unique case (state_q)
			scps_pkg::ST_IDLE: begin
				if (job_valid) begin
					dx_q <= scps_pkg::word_t'(job.dx);
					dy_q <= scps_pkg::word_t'(job.dy);
					dw_q <= scps_pkg::word_t'(job.dw);
					dh_q <= scps_pkg::word_t'(job.dh);
					sx_q <= scps_pkg::word_t'(job.sx);
					sy_q <= scps_pkg::word_t'(job.sy);
					sw_q <= scps_pkg::word_t'(job.sw);
					sh_q <= scps_pkg::word_t'(job.sh);
					flip_q <= job.flip;
					pages_q <= job.pages;
					tw_half_q <= job.tw_half;
					th_half_q <= job.th_half;
					xcase_q <= job.xcase;
					ycase_q <= job.ycase;
					xwide_q <= job.xwide;
					ywide_q <= job.ywide;
				end
			end
			scps_pkg::ST_X0: begin
				if (md_done) begin
					if (!flip_q[0]) begin
						sx_q <= scps_pkg::sat_w(scps_pkg::wext(sx_q) - scps_pkg::wext(m));
					end
					if (!xwide_q) begin
						sw_q <= scps_pkg::sat_w(scps_pkg::wext(sw_q) + scps_pkg::wext(m));
						dw_q <= scps_pkg::sat_w(scps_pkg::wext(dw_q) + scps_pkg::wext(dx_q));
						dx_q <= '0;
					end
				end
			end
			scps_pkg::ST_X1: begin
				if (md_done) begin
					sx_q <= scps_pkg::sat_w(scps_pkg::wext(sx_q) + scps_pkg::wext(m));
				end
			end
			scps_pkg::ST_X2: begin
				if (md_done) begin
					sw_q <= m;
					if (xcase_q == scps_pkg::CLIP_NEG) begin
						dw_q <= vw;
						dx_q <= '0;
					end else begin
						dw_q <= scps_pkg::sat_w(scps_pkg::wext(vw) - scps_pkg::wext(dx_q));
					end
				end
			end
			scps_pkg::ST_Y0: begin
				if (md_done) begin
					if (!flip_q[1]) begin
						sy_q <= scps_pkg::sat_w(scps_pkg::wext(sy_q) - scps_pkg::wext(m));
					end
					if (!ywide_q) begin
						sh_q <= scps_pkg::sat_w(scps_pkg::wext(sh_q) + scps_pkg::wext(m));
						dh_q <= scps_pkg::sat_w(scps_pkg::wext(dh_q) + scps_pkg::wext(dy_q));
						dy_q <= '0;
					end
				end
			end
			scps_pkg::ST_Y1: begin
				if (md_done) begin
					sy_q <= scps_pkg::sat_w(scps_pkg::wext(sy_q) + scps_pkg::wext(m));
				end
			end
			scps_pkg::ST_Y2: begin
				if (md_done) begin
					sh_q <= m;
					if (ycase_q == scps_pkg::CLIP_NEG) begin
						dh_q <= vh;
						dy_q <= '0;
					end else begin
						dh_q <= scps_pkg::sat_w(scps_pkg::wext(vh) - scps_pkg::wext(dy_q));
					end
				end
			end
			scps_pkg::ST_TX: begin
				if (md_done) begin
					dw_q <= m;
					sw_q <= scps_pkg::sat_w(scps_pkg::wext(tw) - scps_pkg::wext(sx_q));
				end
			end
			scps_pkg::ST_TY: begin
				if (md_done) begin
					dh_q <= m;
					sh_q <= scps_pkg::sat_w(scps_pkg::wext(th) - scps_pkg::wext(sy_q));
				end
			end
			scps_pkg::ST_PG: begin
				sy_q <= pg_sy;
				main_q <= pg_main;
				main_v_q <= pg_main_v;
				top_q <= pg_top;
			end
			scps_pkg::ST_PT: begin
				if (md_done) begin
					part_q <= m;
				end
			end
			scps_pkg::ST_ET: begin
				if (slot_free) begin
					dy_q <= scps_pkg::sat_w(scps_pkg::wext(dy_q) + scps_pkg::wext(part_q));
					dh_q <= scps_pkg::sat_w(scps_pkg::wext(dh_q) - scps_pkg::wext(part_q));
					sh_q <= scps_pkg::sat_w(scps_pkg::wext(sh_q)
						- (scps_pkg::wext(PG) - scps_pkg::wext(sy_q)));
					sy_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign draw_valid = draw_valid_q;
	assign draw = draw_q;

endmodule

>>> rtl/scps_checker.sv
// ----------------------------------------------------------------------------
// scps_checker: port-level checks for the sprite clip and page split unit
// Watches the draw channel for transfer rules and page numbering.
// ----------------------------------------------------------------------------
module scps_checker (
	input logic clk,
	input logic arst_n,
	input logic draw_valid,
	input logic draw_stall,
	input scps_pkg::draw_t draw
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		draw_valid && draw_stall |=> draw_valid)
		else $error("draw_valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		draw_valid && draw_stall |=> $stable(draw))
		else $error("draw payload changed while stalled");

	a_page_range: assert property (@(posedge clk) disable iff (!arst_n)
		draw_valid |-> draw.page_index != 2'd3)
		else $error("draw page index out of range");

	a_upper_piece_page: assert property (@(posedge clk) disable iff (!arst_n)
		draw_valid && !draw.last_piece |-> draw.page_index == 2'd0
			|| draw.page_index == 2'd1)
		else $error("a piece before the last one is on the third page");

endmodule

bind sprite_clip_and_page_split_unit scps_checker u_scps_checker (
	.clk(clk),
	.arst_n(arst_n),
	.draw_valid(draw_valid),
	.draw_stall(draw_stall),
	.draw(draw)
);
